// ===== rtl/wfcm_pkg.sv =====
// Shared types and constants of the window flow control monitor.
package wfcm_pkg;

    localparam int COUNT_WIDTH = 48;
    localparam int FIELD_WIDTH = 48;
    localparam int SIZE_WIDTH  = 32;
    localparam int TCOUNT_WIDTH = 8;

    localparam logic [FIELD_WIDTH-1:0] PENDING_BYTES_RESET   = 48'd1048576;
    localparam logic [FIELD_WIDTH-1:0] PENDING_PACKETS_RESET = 48'd64;
    localparam logic [SIZE_WIDTH-1:0]  MAX_TRANSFER_RESET    = 32'd65536;

    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef logic [TCOUNT_WIDTH-1:0] tcount_t;

    typedef enum logic [1:0] {
        CMD_SENT = 2'd0,
        CMD_RECV = 2'd1,
        CMD_ACK  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        EV_KEEP     = 2'd0,
        EV_THROTTLE = 2'd1,
        EV_LIFT     = 2'd2,
        EV_REPORT   = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        REG_PENDING_BYTES   = 2'd0,
        REG_PENDING_PACKETS = 2'd1,
        REG_MAX_TRANSFER    = 2'd2,
        REG_MONITOR_MODE    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]             command;
        logic [SIZE_WIDTH-1:0]  size;
        logic [FIELD_WIDTH-1:0] ack_bytes;
        logic [FIELD_WIDTH-1:0] ack_packets;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]             event_res;
        logic                   can_send;
        logic [FIELD_WIDTH-1:0] report_rx_bytes;
        logic [FIELD_WIDTH-1:0] report_rx_packets;
        logic [FIELD_WIDTH-1:0] tx_bytes_total;
        logic                   overshoot_valid;
        logic [FIELD_WIDTH-1:0] overshoot_bytes;
        logic [FIELD_WIDTH-1:0] overshoot_packets;
    } res_item_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] pending_bytes_limit;
        logic [FIELD_WIDTH-1:0] pending_packets_limit;
        logic [SIZE_WIDTH-1:0]  max_transfer_bytes;
        logic                   monitor_mode;
    } cfg_t;

    // State as it stands after one item, carried to the result stage.
    typedef struct packed {
        event_t  ev;
        tcount_t throttle_count;
        count_t  tx_backlog_bytes;
        count_t  tx_backlog_packets;
        count_t  rx_bytes;
        count_t  rx_packets;
        count_t  tx_bytes;
    } snap_t;

endpackage

// ===== rtl/wfcm_update.sv =====
// Counter and throttle state update for one item, with the snapshot register.
module wfcm_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  wfcm_pkg::cmd_item_t item,
    input  logic                stage_ready,
    input  wfcm_pkg::cfg_t      cfg,
    output logic                snap_valid,
    output wfcm_pkg::snap_t     snap
);

    wfcm_pkg::count_t  sent_bytes_reg, sent_bytes_next;
    wfcm_pkg::count_t  sent_packets_reg, sent_packets_next;
    wfcm_pkg::count_t  acked_bytes_reg, acked_bytes_next;
    wfcm_pkg::count_t  acked_packets_reg, acked_packets_next;
    wfcm_pkg::count_t  tx_bl_bytes_reg, tx_bl_bytes_next;
    wfcm_pkg::count_t  tx_bl_packets_reg, tx_bl_packets_next;
    wfcm_pkg::count_t  rx_bytes_reg, rx_bytes_next;
    wfcm_pkg::count_t  rx_packets_reg, rx_packets_next;
    wfcm_pkg::count_t  rx_bl_bytes_reg, rx_bl_bytes_next;
    wfcm_pkg::count_t  rx_bl_packets_reg, rx_bl_packets_next;
    wfcm_pkg::tcount_t tcount_reg, tcount_next;
    logic              snap_valid_reg, snap_valid_next;
    wfcm_pkg::snap_t   snap_reg, snap_next;

    wfcm_pkg::count_t  size_cw;
    wfcm_pkg::count_t  ack_b;
    wfcm_pkg::count_t  ack_p;
    wfcm_pkg::count_t  lim_b;
    wfcm_pkg::count_t  lim_p;
    wfcm_pkg::count_t  new_bl_b;
    wfcm_pkg::count_t  new_bl_p;
    wfcm_pkg::count_t  ack_bl_b;
    wfcm_pkg::count_t  ack_bl_p;
    wfcm_pkg::cmd_t    cmd;
    wfcm_pkg::event_t  ev;
    logic              size_ok;
    logic              take;
    logic              lb, lp, nb, np;
    logic              last_above, now_above;

    assign take = item_valid && stage_ready;

    always_comb
    begin
        cmd     = wfcm_pkg::cmd_t'(item.command);
        size_cw = wfcm_pkg::COUNT_WIDTH'(item.size);
        ack_b   = wfcm_pkg::COUNT_WIDTH'(item.ack_bytes);
        ack_p   = wfcm_pkg::COUNT_WIDTH'(item.ack_packets);
        lim_b   = wfcm_pkg::COUNT_WIDTH'(cfg.pending_bytes_limit);
        lim_p   = wfcm_pkg::COUNT_WIDTH'(cfg.pending_packets_limit);
        size_ok = (item.size != '0) && (item.size <= cfg.max_transfer_bytes);

        sent_bytes_next    = sent_bytes_reg;
        sent_packets_next  = sent_packets_reg;
        acked_bytes_next   = acked_bytes_reg;
        acked_packets_next = acked_packets_reg;
        tx_bl_bytes_next   = tx_bl_bytes_reg;
        tx_bl_packets_next = tx_bl_packets_reg;
        rx_bytes_next      = rx_bytes_reg;
        rx_packets_next    = rx_packets_reg;
        rx_bl_bytes_next   = rx_bl_bytes_reg;
        rx_bl_packets_next = rx_bl_packets_reg;
        tcount_next        = tcount_reg;
        ev                 = wfcm_pkg::EV_KEEP;

        new_bl_b   = '0;
        new_bl_p   = '0;
        lb         = 1'b0;
        lp         = 1'b0;
        ack_bl_b   = sent_bytes_reg - ack_b;
        ack_bl_p   = sent_packets_reg - ack_p;
        last_above = (tx_bl_bytes_reg >= lim_b) || (tx_bl_packets_reg >= lim_p);
        now_above  = (ack_bl_b >= lim_b) || (ack_bl_p >= lim_p);

        unique case (cmd)
            wfcm_pkg::CMD_SENT:
            begin
                lb       = tx_bl_bytes_reg >= lim_b;
                lp       = tx_bl_packets_reg >= lim_p;
                new_bl_b = tx_bl_bytes_reg + size_cw;
                new_bl_p = tx_bl_packets_reg + wfcm_pkg::COUNT_WIDTH'(1);
            end
            wfcm_pkg::CMD_RECV:
            begin
                lb       = rx_bl_bytes_reg >= lim_b;
                lp       = rx_bl_packets_reg >= lim_p;
                new_bl_b = rx_bl_bytes_reg + size_cw;
                new_bl_p = rx_bl_packets_reg + wfcm_pkg::COUNT_WIDTH'(1);
            end
            wfcm_pkg::CMD_ACK,
            wfcm_pkg::CMD_NONE:
            begin
                new_bl_b = '0;
                new_bl_p = '0;
            end
            default:
            begin
                new_bl_b = '0;
                new_bl_p = '0;
            end
        endcase
        nb = new_bl_b >= lim_b;
        np = new_bl_p >= lim_p;

        unique case (cmd)
            wfcm_pkg::CMD_SENT:
            begin
                if (size_ok)
                begin
                    sent_bytes_next    = sent_bytes_reg + size_cw;
                    sent_packets_next  = sent_packets_reg + wfcm_pkg::COUNT_WIDTH'(1);
                    tx_bl_bytes_next   = new_bl_b;
                    tx_bl_packets_next = new_bl_p;
                    if ((lb != nb) || (lp != np))
                    begin
                        tcount_next = tcount_reg + wfcm_pkg::TCOUNT_WIDTH'(1);
                        if (tcount_next == wfcm_pkg::TCOUNT_WIDTH'(1))
                            ev = wfcm_pkg::EV_THROTTLE;
                    end
                end
            end
            wfcm_pkg::CMD_RECV:
            begin
                if (size_ok)
                begin
                    rx_bytes_next   = rx_bytes_reg + size_cw;
                    rx_packets_next = rx_packets_reg + wfcm_pkg::COUNT_WIDTH'(1);
                    if ((lb != nb) || (lp != np))
                    begin
                        // The receive marks snap to the totals, so the backlog empties.
                        ev                 = wfcm_pkg::EV_REPORT;
                        rx_bl_bytes_next   = '0;
                        rx_bl_packets_next = '0;
                    end
                    else
                    begin
                        rx_bl_bytes_next   = new_bl_b;
                        rx_bl_packets_next = new_bl_p;
                    end
                end
            end
            wfcm_pkg::CMD_ACK:
            begin
                if ((ack_b > acked_bytes_reg) && (ack_p > acked_packets_reg))
                begin
                    acked_bytes_next   = ack_b;
                    acked_packets_next = ack_p;
                    tx_bl_bytes_next   = ack_bl_b;
                    tx_bl_packets_next = ack_bl_p;
                    if (last_above != now_above)
                    begin
                        tcount_next = tcount_reg - wfcm_pkg::TCOUNT_WIDTH'(1);
                        if (tcount_next == '0)
                            ev = wfcm_pkg::EV_LIFT;
                    end
                end
            end
            wfcm_pkg::CMD_NONE:
            begin
                ev = wfcm_pkg::EV_KEEP;
            end
            default:
            begin
                ev = wfcm_pkg::EV_KEEP;
            end
        endcase

        snap_next.ev                 = ev;
        snap_next.throttle_count     = tcount_next;
        snap_next.tx_backlog_bytes   = tx_bl_bytes_next;
        snap_next.tx_backlog_packets = tx_bl_packets_next;
        snap_next.rx_bytes           = rx_bytes_next;
        snap_next.rx_packets         = rx_packets_next;
        snap_next.tx_bytes           = sent_bytes_next;

        if (take)
            snap_valid_next = 1'b1;
        else if (stage_ready)
            snap_valid_next = 1'b0;
        else
            snap_valid_next = snap_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_bytes_reg    <= '0;
            sent_packets_reg  <= '0;
            acked_bytes_reg   <= '0;
            acked_packets_reg <= '0;
            tx_bl_bytes_reg   <= '0;
            tx_bl_packets_reg <= '0;
            rx_bytes_reg      <= '0;
            rx_packets_reg    <= '0;
            rx_bl_bytes_reg   <= '0;
            rx_bl_packets_reg <= '0;
            tcount_reg        <= '0;
            snap_valid_reg    <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (take)
            begin
                sent_bytes_reg    <= sent_bytes_next;
                sent_packets_reg  <= sent_packets_next;
                acked_bytes_reg   <= acked_bytes_next;
                acked_packets_reg <= acked_packets_next;
                tx_bl_bytes_reg   <= tx_bl_bytes_next;
                tx_bl_packets_reg <= tx_bl_packets_next;
                rx_bytes_reg      <= rx_bytes_next;
                rx_packets_reg    <= rx_packets_next;
                rx_bl_bytes_reg   <= rx_bl_bytes_next;
                rx_bl_packets_reg <= rx_bl_packets_next;
                tcount_reg        <= tcount_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== rtl/wfcm_result.sv =====
// Overshoot and send permission for one snapshot, with the result register.
module wfcm_result (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                snap_valid,
    input  wfcm_pkg::snap_t     snap,
    input  wfcm_pkg::cfg_t      cfg,
    output logic                stage_ready,
    output logic                res_valid,
    input  logic                res_ready,
    output wfcm_pkg::res_item_t res_item
);

    logic                res_valid_reg, res_valid_next;
    wfcm_pkg::res_item_t res_reg, res_next;

    wfcm_pkg::count_t    lim_b;
    wfcm_pkg::count_t    lim_p;
    wfcm_pkg::count_t    over_b;
    wfcm_pkg::count_t    over_p;
    logic                count_zero;
    logic                take;

    assign stage_ready = !res_valid_reg || res_ready;
    assign take        = snap_valid && stage_ready;

    always_comb
    begin
        lim_b      = wfcm_pkg::COUNT_WIDTH'(cfg.pending_bytes_limit);
        lim_p      = wfcm_pkg::COUNT_WIDTH'(cfg.pending_packets_limit);
        over_b     = snap.tx_backlog_bytes - lim_b;
        over_p     = snap.tx_backlog_packets - lim_p;
        count_zero = snap.throttle_count == '0;

        res_next.event_res         = snap.ev;
        res_next.can_send          = count_zero || cfg.monitor_mode;
        res_next.report_rx_bytes   = wfcm_pkg::FIELD_WIDTH'(snap.rx_bytes);
        res_next.report_rx_packets = wfcm_pkg::FIELD_WIDTH'(snap.rx_packets);
        res_next.tx_bytes_total    = wfcm_pkg::FIELD_WIDTH'(snap.tx_bytes);
        res_next.overshoot_valid   = 1'b0;
        res_next.overshoot_bytes   = '0;
        res_next.overshoot_packets = '0;

        // The packet backlog takes precedence over the byte backlog.
        priority if (count_zero && (snap.tx_backlog_packets > lim_p))
        begin
            res_next.overshoot_valid   = 1'b1;
            res_next.overshoot_packets = wfcm_pkg::FIELD_WIDTH'(over_p);
        end
        else if (count_zero && (snap.tx_backlog_bytes > lim_b))
        begin
            res_next.overshoot_valid = 1'b1;
            res_next.overshoot_bytes = wfcm_pkg::FIELD_WIDTH'(over_b);
        end
        else
        begin
            res_next.overshoot_valid = 1'b0;
        end

        if (take)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

// ===== rtl/window_flow_control_monitor.sv =====
// Top level of the window flow control monitor: input register, configuration and stages.
//
// Usage: items enter on cmd_valid/cmd_ready/cmd_item (sent packet, received
// packet or peer acknowledgement) and each gives exactly one result on
// res_valid/res_ready/res_item, in order. Configuration registers are written
// on cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high,
// and the user must make writes only while no item is in flight; the block
// itself does not enforce it. The input register loads an accepted item, then
// the state update goes into the snapshot register and the overshoot into the
// result register. Throughput: one item per cycle while res_ready stays high;
// the state update of one item completes in the cycle it leaves the input
// register, so the next item sees it at once. Reset clears all counters, marks
// and the throttle count, loads the register defaults and empties every stage.
// When the receiver holds res_ready low the stages fill one by one; up to three
// items are held before cmd_ready falls, and nothing is lost or repeated.
module window_flow_control_monitor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  wfcm_pkg::cmd_item_t cmd_item,
    output logic                res_valid,
    input  logic                res_ready,
    output wfcm_pkg::res_item_t res_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [wfcm_pkg::FIELD_WIDTH-1:0] cfg_data
);

    logic                in_valid_reg, in_valid_next;
    wfcm_pkg::cmd_item_t in_item_reg;
    wfcm_pkg::cfg_t      cfg_reg, cfg_next;

    logic                snap_valid;
    wfcm_pkg::snap_t     snap;
    logic                res_stage_ready;
    logic                upd_ready;
    logic                cmd_take;

    assign cfg_ready = 1'b1;
    assign upd_ready = !snap_valid || res_stage_ready;
    assign cmd_ready = !in_valid_reg || upd_ready;
    assign cmd_take  = cmd_valid && cmd_ready;

    always_comb
    begin
        if (cmd_take)
            in_valid_next = 1'b1;
        else if (upd_ready)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (wfcm_pkg::reg_index_t'(cfg_index))
                wfcm_pkg::REG_PENDING_BYTES:
                    cfg_next.pending_bytes_limit = cfg_data;
                wfcm_pkg::REG_PENDING_PACKETS:
                    cfg_next.pending_packets_limit = cfg_data;
                wfcm_pkg::REG_MAX_TRANSFER:
                    cfg_next.max_transfer_bytes = cfg_data[wfcm_pkg::SIZE_WIDTH-1:0];
                wfcm_pkg::REG_MONITOR_MODE:
                    cfg_next.monitor_mode = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                  <= 1'b0;
            cfg_reg.pending_bytes_limit   <= wfcm_pkg::PENDING_BYTES_RESET;
            cfg_reg.pending_packets_limit <= wfcm_pkg::PENDING_PACKETS_RESET;
            cfg_reg.max_transfer_bytes    <= wfcm_pkg::MAX_TRANSFER_RESET;
            cfg_reg.monitor_mode          <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            in_item_reg <= cmd_item;
    end

    wfcm_update u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_valid_reg),
        .item        (in_item_reg),
        .stage_ready (upd_ready),
        .cfg         (cfg_reg),
        .snap_valid  (snap_valid),
        .snap        (snap)
    );

    wfcm_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap_valid  (snap_valid),
        .snap        (snap),
        .cfg         (cfg_reg),
        .stage_ready (res_stage_ready),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_item    (res_item)
    );

endmodule
